/* rtl/core/stt_pkg.sv */
// Shared types and constants of the source text tokenizer.
// Token kinds, token word layout and the keyword table; no dependencies.
package stt_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [5:0] K_EOF       = 6'd0;
    localparam logic [5:0] K_IDENT     = 6'd11;
    localparam logic [5:0] K_NUMBER    = 6'd12;
    localparam logic [5:0] K_STRING    = 6'd13;
    localparam logic [5:0] K_CHAR      = 6'd14;
    localparam logic [5:0] K_COLON     = 6'd15;
    localparam logic [5:0] K_SEMI      = 6'd16;
    localparam logic [5:0] K_EQUAL     = 6'd17;
    localparam logic [5:0] K_PLUS      = 6'd18;
    localparam logic [5:0] K_PLUS_EQ   = 6'd19;
    localparam logic [5:0] K_PLUS_PLUS = 6'd20;
    localparam logic [5:0] K_LT        = 6'd21;
    localparam logic [5:0] K_GT        = 6'd22;
    localparam logic [5:0] K_LE        = 6'd23;
    localparam logic [5:0] K_GE        = 6'd24;
    localparam logic [5:0] K_EQEQ      = 6'd25;
    localparam logic [5:0] K_BANG_EQ   = 6'd26;
    localparam logic [5:0] K_LBRACE    = 6'd27;
    localparam logic [5:0] K_RBRACE    = 6'd28;
    localparam logic [5:0] K_LPAREN    = 6'd29;
    localparam logic [5:0] K_RPAREN    = 6'd30;
    localparam logic [5:0] K_COMMA     = 6'd31;
    localparam logic [5:0] K_UNKNOWN   = 6'd32;

    localparam int NUM_KW = 10;

    // keyword text, first byte lowest, zero padded
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'h000000726176,  // var
        48'h0000006E7566,  // fun
        48'h000000006669,  // if
        48'h00656C696877,  // while
        48'h000000726F66,  // for
        48'h746375727473,  // struct
        48'h7265626D756E,  // number
        48'h676E69727473,  // string
        48'h000064696F76,  // void
        48'h000000746E69   // int
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd3, 3'd2, 3'd5, 3'd3, 3'd6, 3'd6, 3'd6, 3'd4, 3'd3
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [6:0]  len;
        logic        last;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_tok_slot;

    // Bytes past the identifier length are zero in the window, so a full
    // compare plus a length compare is an exact match.
    function automatic logic [5:0] kw_match(input logic [47:0] win,
                                            input logic [2:0]  len);
        logic [5:0] kind;
        kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (KW_LEN[k] == len && KW_TEXT[k] == win) begin
                kind = 6'(k + 1);
            end
        end
        return kind;
    endfunction

endpackage

/* rtl/core/stt_scan.sv */
// Scanner state and per-byte next-state logic of the tokenizer.
// Produces up to two tokens per byte; depends on stt_pkg.
module stt_scan #(
    parameter int LEXEME_CAP    = 127,
    parameter int POSITION_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_end,
    output stt_pkg::t_tok_slot o_tok0,
    output stt_pkg::t_tok_slot o_tok1
);
    import stt_pkg::*;

    localparam int LEN_BITS = $clog2(LEXEME_CAP + 1);
    localparam logic [LEN_BITS-1:0] CAP = LEN_BITS'(LEXEME_CAP);

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_BLOCK, M_LINE, M_IDENT, M_NUMBER, M_STRING,
        M_STRING_ESC, M_CHAR_FIRST, M_CHAR_AFTER_ESC, M_CHAR_CLOSE,
        M_OP_EQ, M_OP_PLUS, M_OP_LT, M_OP_GT, M_OP_BANG
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [31:0]              r_pstart, n_pstart;
    logic [LEN_BITS-1:0]      r_plen, n_plen;
    logic [47:0]              r_win, n_win;
    logic                     r_star, n_star;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [63:0]              pos64, pos_inc64;
    logic [31:0]              pos32, pos_inc32;
    logic [LEN_BITS-1:0]      len_inc, len_inc2;
    logic [6:0]               plen7;
    logic [5:0]               id_kind;
    logic                     is_alpha, is_digit, is_space;

    t_tok_slot fl_tok;
    t_tok_slot id_tok;
    logic      id_pend, id_win_load;
    t_mode     id_mode;
    logic [31:0]         id_pstart;
    logic [LEN_BITS-1:0] id_plen;

    t_tok_slot tok_a, tok_b;
    logic      use_fl, again;

    assign pos_inc   = r_pos + 1'b1;
    assign pos64     = 64'(r_pos);
    assign pos_inc64 = 64'(pos_inc);
    assign pos32     = pos64[31:0];
    assign pos_inc32 = pos_inc64[31:0];
    assign len_inc   = (r_plen < CAP) ? r_plen + 1'b1 : CAP;
    assign len_inc2  = (r_plen < CAP - 1'b1) ? r_plen + 2'd2 : CAP;
    assign plen7     = 7'(r_plen);
    assign id_kind   = (r_plen <= LEN_BITS'(6)) ? kw_match(r_win, r_plen[2:0]) : K_IDENT;
    assign is_alpha  = (i_byte inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F});
    assign is_digit  = (i_byte inside {[8'h30:8'h39]});
    assign is_space  = (i_byte inside {8'h20, [8'h09:8'h0D]});

    // token that a pending mode yields when cut off
    always_comb begin
        fl_tok           = '0;
        fl_tok.tok.start = r_pstart;
        fl_tok.tok.len   = 7'd1;
        fl_tok.valid     = 1'b1;
        case (r_mode)
            M_SLASH:   fl_tok.tok.kind = K_UNKNOWN;
            M_IDENT: begin
                fl_tok.tok.kind = id_kind;
                fl_tok.tok.len  = plen7;
            end
            M_NUMBER: begin
                fl_tok.tok.kind = K_NUMBER;
                fl_tok.tok.len  = plen7;
            end
            M_STRING, M_STRING_ESC: begin
                fl_tok.tok.kind = K_STRING;
                fl_tok.tok.len  = plen7;
            end
            M_CHAR_FIRST, M_CHAR_AFTER_ESC, M_CHAR_CLOSE: begin
                fl_tok.tok.kind = K_CHAR;
                fl_tok.tok.len  = plen7;
            end
            M_OP_EQ:   fl_tok.tok.kind = K_EQUAL;
            M_OP_PLUS: fl_tok.tok.kind = K_PLUS;
            M_OP_LT:   fl_tok.tok.kind = K_LT;
            M_OP_GT:   fl_tok.tok.kind = K_GT;
            M_OP_BANG: fl_tok.tok.kind = K_UNKNOWN;
            default:   fl_tok.valid    = 1'b0;
        endcase
    end

    // scan of the byte as the start of a new token
    always_comb begin
        id_tok           = '0;
        id_tok.tok.start = pos32;
        id_tok.tok.len   = 7'd1;
        id_pend          = 1'b0;
        id_mode          = M_IDLE;
        id_pstart        = pos32;
        id_plen          = '0;
        id_win_load      = 1'b0;
        case (i_byte)
            CH_COLON:  {id_tok.valid, id_tok.tok.kind} = {1'b1, K_COLON};
            CH_SEMI:   {id_tok.valid, id_tok.tok.kind} = {1'b1, K_SEMI};
            CH_LBRACE: {id_tok.valid, id_tok.tok.kind} = {1'b1, K_LBRACE};
            CH_RBRACE: {id_tok.valid, id_tok.tok.kind} = {1'b1, K_RBRACE};
            CH_LPAREN: {id_tok.valid, id_tok.tok.kind} = {1'b1, K_LPAREN};
            CH_RPAREN: {id_tok.valid, id_tok.tok.kind} = {1'b1, K_RPAREN};
            CH_COMMA:  {id_tok.valid, id_tok.tok.kind} = {1'b1, K_COMMA};
            CH_SLASH: begin
                id_pend = 1'b1;
                id_mode = M_SLASH;
            end
            CH_EQ: begin
                id_pend = 1'b1;
                id_mode = M_OP_EQ;
            end
            CH_PLUS: begin
                id_pend = 1'b1;
                id_mode = M_OP_PLUS;
            end
            CH_LT: begin
                id_pend = 1'b1;
                id_mode = M_OP_LT;
            end
            CH_GT: begin
                id_pend = 1'b1;
                id_mode = M_OP_GT;
            end
            CH_BANG: begin
                id_pend = 1'b1;
                id_mode = M_OP_BANG;
            end
            CH_DQUOTE: begin
                id_pend   = 1'b1;
                id_mode   = M_STRING;
                id_pstart = pos_inc32;
            end
            CH_SQUOTE: begin
                id_pend   = 1'b1;
                id_mode   = M_CHAR_FIRST;
                id_pstart = pos_inc32;
            end
            default: begin
                if (is_space) begin
                    id_pend = 1'b0;
                end else if (is_alpha) begin
                    id_pend     = 1'b1;
                    id_mode     = M_IDENT;
                    id_plen     = LEN_BITS'(1);
                    id_win_load = 1'b1;
                end else if (is_digit) begin
                    id_pend = 1'b1;
                    id_mode = M_NUMBER;
                    id_plen = LEN_BITS'(1);
                end else begin
                    {id_tok.valid, id_tok.tok.kind} = {1'b1, K_UNKNOWN};
                end
            end
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = pos_inc;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_win    = r_win;
        n_star   = r_star;
        use_fl   = 1'b0;
        again    = 1'b0;
        tok_b    = '0;
        tok_b.tok.start = r_pstart;
        tok_b.tok.len   = 7'd2;
        if (i_end) begin
            use_fl          = 1'b1;
            tok_b.valid     = 1'b1;
            tok_b.tok.kind  = K_EOF;
            tok_b.tok.start = pos32;
            tok_b.tok.len   = 7'd0;
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_pstart = '0;
            n_plen   = '0;
            n_win    = '0;
            n_star   = 1'b0;
        end else begin
            case (r_mode)
                M_SLASH: begin
                    if (i_byte == CH_STAR) begin
                        n_mode = M_BLOCK;
                        n_star = 1'b0;
                    end else if (i_byte == CH_SLASH) begin
                        n_mode = M_LINE;
                    end else begin
                        use_fl = 1'b1;
                        again  = 1'b1;
                    end
                end
                M_BLOCK: begin
                    if (r_star && i_byte == CH_SLASH) begin
                        n_mode = M_IDLE;
                        n_star = 1'b0;
                    end else begin
                        n_star = (i_byte == CH_STAR);
                    end
                end
                M_LINE: begin
                    if (i_byte == CH_LF) n_mode = M_IDLE;
                end
                M_IDENT: begin
                    if (is_alpha || is_digit) begin
                        for (int i = 0; i < 6; i++) begin
                            if (r_plen == LEN_BITS'(i)) n_win[8*i +: 8] = i_byte;
                        end
                        n_plen = len_inc;
                    end else begin
                        use_fl = 1'b1;
                        again  = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit) begin
                        n_plen = len_inc;
                    end else begin
                        use_fl = 1'b1;
                        again  = 1'b1;
                    end
                end
                M_STRING: begin
                    if (i_byte == CH_DQUOTE) begin
                        use_fl = 1'b1;
                        n_mode = M_IDLE;
                    end else if (i_byte == CH_BSLASH) begin
                        n_mode = M_STRING_ESC;
                    end else begin
                        n_plen = len_inc;
                    end
                end
                M_STRING_ESC: begin
                    n_plen = len_inc2;
                    n_mode = M_STRING;
                end
                M_CHAR_FIRST: begin
                    if (i_byte == CH_SQUOTE) begin
                        use_fl = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        n_plen = LEN_BITS'(1);
                        n_mode = (i_byte == CH_BSLASH) ? M_CHAR_AFTER_ESC : M_CHAR_CLOSE;
                    end
                end
                M_CHAR_AFTER_ESC: begin
                    if (i_byte == CH_SQUOTE) begin
                        use_fl = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        n_plen = LEN_BITS'(2);
                        n_mode = M_CHAR_CLOSE;
                    end
                end
                M_CHAR_CLOSE: begin
                    if (i_byte == CH_SQUOTE) begin
                        use_fl = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_OP_EQ, M_OP_LT, M_OP_GT, M_OP_BANG: begin
                    if (i_byte == CH_EQ) begin
                        tok_b.valid = 1'b1;
                        case (r_mode)
                            M_OP_EQ:  tok_b.tok.kind = K_EQEQ;
                            M_OP_LT:  tok_b.tok.kind = K_LE;
                            M_OP_GT:  tok_b.tok.kind = K_GE;
                            default:  tok_b.tok.kind = K_BANG_EQ;
                        endcase
                        n_mode = M_IDLE;
                    end else begin
                        use_fl = 1'b1;
                        again  = 1'b1;
                    end
                end
                M_OP_PLUS: begin
                    if (i_byte == CH_EQ || i_byte == CH_PLUS) begin
                        tok_b.valid    = 1'b1;
                        tok_b.tok.kind = (i_byte == CH_EQ) ? K_PLUS_EQ : K_PLUS_PLUS;
                        n_mode         = M_IDLE;
                    end else begin
                        use_fl = 1'b1;
                        again  = 1'b1;
                    end
                end
                default: again = 1'b1;
            endcase
            if (again) begin
                tok_b = id_tok;
                if (id_pend) begin
                    n_mode   = id_mode;
                    n_pstart = id_pstart;
                    n_plen   = id_plen;
                    if (id_win_load) n_win = {40'd0, i_byte};
                end else begin
                    n_mode = M_IDLE;
                end
            end
        end
    end

    always_comb begin
        tok_a  = use_fl ? fl_tok : '0;
        o_tok0 = tok_a.valid ? tok_a : tok_b;
        o_tok1 = tok_a.valid ? tok_b : '0;
        o_tok0.tok.last = !o_tok1.valid;
        o_tok1.tok.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_win    <= '0;
            r_star   <= 1'b0;
        end else if (i_valid) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_win    <= n_win;
            r_star   <= n_star;
        end
    end

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_end |=> r_mode == M_IDLE && r_pos == '0)
        else $error("end of input did not restart the scanner");

    a_end_gives_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_end |-> o_tok0.valid && (o_tok1.valid ? o_tok1.tok.kind == K_EOF
                                                           : o_tok0.tok.kind == K_EOF))
        else $error("end of input without EOF token");

    a_tok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok1.valid |-> o_tok0.valid)
        else $error("second token slot used alone");

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= CAP)
        else $error("pending length above cap");

endmodule

/* rtl/core/source_text_tokenizer.sv */
// Source text tokenizer: one byte word in, tokens out as (kind, start, length).
// Output: a token is queued when the byte that ends it is accepted and offered in queue order.
// Throughput: one byte per cycle while the queue accepts; a byte that closes two tokens
// pushes both into a four-entry token queue that accepts while two slots are free.
// Reset: synchronous, active low; scanner idle, position zero, queue empty.
// Depends on stt_pkg and stt_scan.
module source_text_tokenizer #(
    parameter int LEXEME_CAP    = 127,
    parameter int POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic [0:0]  i_s_tuser,   // [0] end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] lexeme_start, [38:32] lexeme_length, [39] zero
    output logic [5:0]  o_m_tuser,   // [5:0] token_kind
    output logic        o_m_tlast    // last_of_run
);
    import stt_pkg::*;

    t_tok_slot tok0, tok1;
    logic      in_acc, pop;
    logic [1:0] push_n;

    t_token          r_q [QDEPTH];
    logic [QAW-1:0]  r_wr, r_rd;
    logic [QAW:0]    r_count;

    assign in_acc = i_s_tvalid && o_s_tready;
    assign pop    = o_m_tvalid && i_m_tready;
    assign push_n = in_acc ? (2'(tok0.valid) + 2'(tok1.valid)) : 2'd0;

    assign o_s_tready = (r_count <= (QAW+1)'(QDEPTH - 2));
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = {1'b0, r_q[r_rd].len, r_q[r_rd].start};
    assign o_m_tuser  = r_q[r_rd].kind;
    assign o_m_tlast  = r_q[r_rd].last;

    stt_scan #(
        .LEXEME_CAP   (LEXEME_CAP),
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(in_acc),
        .i_byte (i_s_tdata),
        .i_end  (i_s_tuser[0]),
        .o_tok0 (tok0),
        .o_tok1 (tok1)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc && tok0.valid) r_q[r_wr] <= tok0.tok;
        if (in_acc && tok1.valid) r_q[r_wr + 1'b1] <= tok1.tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QAW'(push_n);
            r_rd    <= r_rd + QAW'(pop);
            r_count <= r_count + (QAW+1)'(push_n) - (QAW+1)'(pop);
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("token queue overflow");

    a_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_s_tuser[0] |=> r_count >= (QAW+1)'(1))
        else $error("end of input left no token queued");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc && pop |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count out of step with pops");

endmodule
